// ===== rtl/fcou_pkg.sv =====
// fly camera orientation update: shared types, codes and constants
// used by rtl/fly_camera_orientation_update_top.sv; no dependencies
package fcou_pkg;

  typedef struct packed {
    logic               action;
    logic signed [23:0] cursor_x;
    logic signed [23:0] cursor_y;
    logic [1:0]         direction;
    logic [15:0]        time_step;
  } cam_in_t;

  typedef struct packed {
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } cam_out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DX, S_DX_W, S_YW, S_YW_W, S_DY, S_DY_W,
    S_CY_INIT, S_CY_RUN, S_CP_INIT, S_CP_RUN,
    S_F_MUL0, S_F_ST0, S_F_MUL2, S_F_ST2,
    S_N_MUL, S_N_ACC, S_N_SQRT, S_N_DIV, S_N_DIV_W, S_N_END,
    S_U_MUL, S_U_ACC,
    S_M_SD, S_M_SD_ST, S_M_MUL, S_M_ADD,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {PH_FRONT, PH_RIGHT, PH_UP} phase_t;

  localparam logic ACT_CURSOR = 1'b0;
  localparam logic ACT_MOVE   = 1'b1;

  // angles in degrees Q16
  localparam int QUARTER_TURN = 5898240;
  localparam int HALF_TURN    = 11796480;
  localparam int FULL_TURN    = 23592960;
  localparam int PITCH_LIMIT  = 5832704;
  localparam int YAW_BIAS     = 766771200;  // half turn plus 32 full turns
  localparam int CORDIC_K     = 652032874;
  localparam int ONE_Q14      = 16384;
  localparam int ONE_Q24      = 16777216;
  localparam logic [15:0] SPEED_RESET = 16'd768;
  localparam int DIV_STEPS    = 30;
  // 2^34 / 5 rounded up, exact floor divide by 5 for 32-bit numerators
  localparam logic [31:0] DEG_RECIP = 32'hcccccccd;
  // yaw wrap subtracts 32, 16, ... 1 full turns
  localparam logic [2:0]  WRAP_TOP  = 3'd5;

  localparam int ATAN_LEN = 24;
  localparam logic [21:0] ATAN_DEG [ATAN_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
    22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
  };

  // Q24 to Q2.14, round half up, saturate
  function automatic logic signed [15:0] to_q14(input logic signed [27:0] v);
    logic signed [28:0] r;
    r = (29'(v) + 29'sd512) >>> 10;
    if (r > 29'sd32767) return 16'sh7fff;
    if (r < -29'sd32768) return 16'sh8000;
    return 16'(r);
  endfunction

endpackage

// ===== rtl/fly_camera_orientation_update_top.sv =====
// fly camera orientation update: top level with sequencer, shared cordic,
// multiplier, bit-serial square root and restoring divider
// depends on rtl/fcou_pkg.sv
//
// the work on a later cursor item is set mostly by the serial divider
// (nine quotients) and by three 28-step square roots
// throughput: one item at a time; in_stall is high from accept until the
// result is handed to the output register, which holds it until taken
// reset (rst, synchronous): position zero, yaw -90, pitch 0, vectors to the
// default frame, speed 3.0, first cursor item only latches
module fly_camera_orientation_update_top
  import fcou_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  cam_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output cam_out_t    out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  // sequencer
  state_t state, state_next;
  phase_t phase;
  logic [1:0] k;
  logic       t;

  // architectural state
  cam_in_t            req;
  logic [15:0]        move_speed;
  logic signed [31:0] pos [3];
  logic signed [24:0] yaw;
  logic signed [23:0] pitch;
  logic signed [23:0] last_x, last_y;
  logic               awaiting;
  logic signed [15:0] fq [3];
  logic signed [15:0] rq [3];
  logic signed [15:0] uq [3];

  // working registers
  logic signed [24:0] dlt_x, dlt_y;
  logic signed [31:0] ang_sum;
  logic [30:0]        wrap_v;
  logic [2:0]         wrap_i;
  logic signed [32:0] cx_r, cy_r;
  logic signed [25:0] cz;
  logic               c_neg;
  logic [IW-1:0]      c_i;
  logic signed [32:0] cos_y, sin_y, cos_p, sin_p;
  logic signed [27:0] fvec [3];
  logic signed [27:0] rvec [3];
  logic signed [27:0] vin  [3];
  logic signed [27:0] vout [3];
  logic [55:0]        sq_v, sq_r, sq_bit;
  logic signed [57:0] acc;
  logic [31:0]        sd;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  // shared restoring divider
  logic        div_start, div_run;
  logic [51:0] div_num;
  logic [27:0] div_den_in, div_den, div_rem;
  logic [29:0] div_lo, div_q;
  logic [4:0]  div_cnt;
  logic [28:0] div_trial;
  logic        div_fit;

  function automatic logic [1:0] nxt(input logic [1:0] v);
    case (v)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  // ---------------------------------------------------------------- helpers
  logic signed [24:0] deg_src;
  logic [24:0]        deg_mag;
  logic [31:0]        deg_num;
  logic signed [31:0] deg_q, deg_delta, pitch_sum;
  logic signed [31:0] yaw_biased;
  logic [30:0]        wrap_m, wrap_sub;
  logic               wrap_fit;
  logic signed [25:0] cord_a, cord_z0;
  logic               cord_neg0;
  logic signed [32:0] cx_s, cy_s, cx_n, cy_n;
  logic signed [25:0] c_atn, cz_n;
  logic               c_last;
  logic signed [65:0] prod_r36;
  logic [27:0]        nrm_len, nrm_mag, nrm_q;
  logic [1:0]         ka1, ka2;
  logic signed [57:0] up_diff;
  logic signed [15:0] axis_k;
  logic signed [33:0] mv_d, mv_dn, mv_n;
  logic               out_load;

  assign deg_src   = (state == S_DX || state == S_DX_W) ? dlt_x : dlt_y;
  assign deg_mag   = deg_src[24] ? 25'(-deg_src) : 25'(deg_src);
  // pixels Q8 times 128 plus 2, then divided by 5 through the reciprocal
  assign deg_num   = {deg_mag, 7'b0000000} + 32'd2;
  assign deg_q     = $signed({2'b00, prod[63:34]});
  assign deg_delta = deg_src[24] ? -deg_q : deg_q;
  assign pitch_sum = 32'(pitch) + deg_delta;
  assign yaw_biased = ang_sum + 32'(YAW_BIAS);

  // one compare and subtract step of the yaw wrap
  assign wrap_m   = 31'(FULL_TURN) << wrap_i;
  assign wrap_fit = (wrap_v >= wrap_m);
  assign wrap_sub = wrap_fit ? wrap_v - wrap_m : wrap_v;

  // quadrant fold for the cordic start angle
  assign cord_a = (state == S_CY_INIT) ? 26'(yaw) : 26'(pitch);
  always_comb begin
    cord_z0   = cord_a;
    cord_neg0 = 1'b0;
    if (cord_a > QUARTER_TURN) begin
      cord_z0   = 26'(cord_a - HALF_TURN);
      cord_neg0 = 1'b1;
    end else if (cord_a < -QUARTER_TURN) begin
      cord_z0   = 26'(cord_a + HALF_TURN);
      cord_neg0 = 1'b1;
    end
  end

  // one cordic rotation step
  assign cx_s  = cx_r >>> c_i;
  assign cy_s  = cy_r >>> c_i;
  assign c_atn = {4'b0000, ATAN_DEG[5'(c_i)]};
  assign cx_n  = cz[25] ? cx_r + cy_s : cx_r - cy_s;
  assign cy_n  = cz[25] ? cy_r - cx_s : cy_r + cx_s;
  assign cz_n  = cz[25] ? cz + c_atn : cz - c_atn;
  assign c_last = (c_i == IW'(CORDIC_STEPS - 1));

  assign prod_r36 = (prod + (66'sd1 <<< 35)) >>> 36;

  assign nrm_len = sq_r[27:0];
  assign nrm_mag = vin[k][27] ? 28'(-vin[k]) : 28'(vin[k]);
  assign nrm_q   = 28'(div_q);

  assign ka1     = nxt(k);
  assign ka2     = nxt(ka1);
  assign up_diff = acc - 58'(prod);

  assign axis_k = req.direction[1] ? rq[k] : fq[k];
  assign mv_d   = 34'((prod + 66'sd2097152) >>> 22);
  assign mv_dn  = req.direction[0] ? -mv_d : mv_d;
  assign mv_n   = 34'(pos[k]) + mv_dn;

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = '0;
    div_den_in = '0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.action == ACT_MOVE) state_next = S_M_SD;
          else if (awaiting) state_next = S_DONE;
          else state_next = S_DX;
        end
      end
      S_DX, S_DY: begin
        mul_a      = {1'b0, deg_num};
        mul_b      = {1'b0, DEG_RECIP};
        state_next = (state == S_DX) ? S_DX_W : S_DY_W;
      end
      S_DX_W:    state_next = S_YW;
      S_YW:      state_next = S_YW_W;
      S_YW_W:    if (wrap_i == 3'd0) state_next = S_DY;
      S_DY_W:    state_next = S_CY_INIT;
      S_CY_INIT: state_next = S_CY_RUN;
      S_CY_RUN:  if (c_last) state_next = S_CP_INIT;
      S_CP_INIT: state_next = S_CP_RUN;
      S_CP_RUN:  if (c_last) state_next = S_F_MUL0;
      S_F_MUL0: begin
        mul_a = cos_y;
        mul_b = cos_p;
        state_next = S_F_ST0;
      end
      S_F_ST0: state_next = S_F_MUL2;
      S_F_MUL2: begin
        mul_a = sin_y;
        mul_b = cos_p;
        state_next = S_F_ST2;
      end
      S_F_ST2: state_next = S_N_MUL;
      S_N_MUL: begin
        mul_a = 33'(vin[k]);
        mul_b = 33'(vin[k]);
        state_next = S_N_ACC;
      end
      S_N_ACC:  state_next = (k == 2'd2) ? S_N_SQRT : S_N_MUL;
      S_N_SQRT: if (sq_bit[0]) state_next = S_N_DIV;
      S_N_DIV: begin
        if (nrm_len == '0) begin
          state_next = S_N_END;
        end else begin
          div_start  = 1'b1;
          div_num    = {nrm_mag, 24'h000000} + 52'(nrm_len >> 1);
          div_den_in = nrm_len;
          state_next = S_N_DIV_W;
        end
      end
      S_N_DIV_W: begin
        if (!div_run) state_next = (k == 2'd2) ? S_N_END : S_N_DIV;
      end
      S_N_END: begin
        case (phase)
          PH_FRONT: state_next = S_N_MUL;
          PH_RIGHT: state_next = S_U_MUL;
          default:  state_next = S_DONE;
        endcase
      end
      S_U_MUL: begin
        mul_a = t ? 33'(rvec[ka2]) : 33'(rvec[ka1]);
        mul_b = t ? 33'(fvec[ka1]) : 33'(fvec[ka2]);
        state_next = S_U_ACC;
      end
      S_U_ACC: state_next = (t && k == 2'd2) ? S_N_MUL : S_U_MUL;
      S_M_SD: begin
        mul_a = {17'b0, move_speed};
        mul_b = {17'b0, req.time_step};
        state_next = S_M_SD_ST;
      end
      S_M_SD_ST: state_next = S_M_MUL;
      S_M_MUL: begin
        mul_a = 33'(axis_k);
        mul_b = {1'b0, sd};
        state_next = S_M_ADD;
      end
      S_M_ADD: state_next = (k == 2'd2) ? S_DONE : S_M_MUL;
      S_DONE:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // --------------------------------------------------------- shared units
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign div_trial = {div_rem, div_lo[DIV_STEPS-1]};
  assign div_fit   = (div_trial >= {1'b0, div_den});

  always_ff @(posedge clk) begin
    if (rst) begin
      div_run <= 1'b0;
      div_cnt <= '0;
    end else if (div_start) begin
      div_run <= 1'b1;
      div_cnt <= '0;
    end else if (div_run) begin
      div_cnt <= div_cnt + 5'd1;
      if (div_cnt == 5'(DIV_STEPS - 1)) div_run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_rem <= 28'(div_num[51:30]);
      div_lo  <= div_num[29:0];
      div_den <= div_den_in;
      div_q   <= '0;
    end else if (div_run) begin
      div_rem <= div_fit ? 28'(div_trial - {1'b0, div_den}) : div_trial[27:0];
      div_lo  <= div_lo << 1;
      div_q   <= {div_q[28:0], div_fit};
    end
  end

  // -------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      move_speed <= SPEED_RESET;
      pos[0]     <= '0;
      pos[1]     <= '0;
      pos[2]     <= '0;
      yaw        <= 25'(-QUARTER_TURN);
      pitch      <= '0;
      last_x     <= '0;
      last_y     <= '0;
      awaiting   <= 1'b1;
      fq[0] <= '0;              fq[1] <= '0;              fq[2] <= 16'(-ONE_Q14);
      rq[0] <= 16'(ONE_Q14);    rq[1] <= '0;              rq[2] <= '0;
      uq[0] <= '0;              uq[1] <= 16'(ONE_Q14);    uq[2] <= '0;
      k     <= '0;
      t     <= 1'b0;
      phase <= PH_FRONT;
    end else begin
      // speed must be written only while no item is in flight; the block itself does not enforce it
      if (cfg_wr_en) move_speed <= cfg_wr_data;
      case (state)
        S_IDLE: begin
          k <= '0;
          if (in_valid) begin
            req <= in_data;
            if (in_data.action == ACT_CURSOR) begin
              dlt_x    <= 25'(in_data.cursor_x) - 25'(last_x);
              dlt_y    <= 25'(last_y) - 25'(in_data.cursor_y);
              last_x   <= in_data.cursor_x;
              last_y   <= in_data.cursor_y;
              awaiting <= 1'b0;
            end
          end
        end
        S_DX_W: ang_sum <= 32'(yaw) + deg_delta;
        S_YW: begin
          wrap_v <= 31'(yaw_biased);
          wrap_i <= WRAP_TOP;
        end
        // wrap into [-180, 180)
        S_YW_W: begin
          wrap_v <= wrap_sub;
          wrap_i <= wrap_i - 3'd1;
          if (wrap_i == 3'd0) yaw <= 25'($signed({1'b0, wrap_sub}) - HALF_TURN);
        end
        S_DY_W: begin
          if (pitch_sum > PITCH_LIMIT) pitch <= 24'(PITCH_LIMIT);
          else if (pitch_sum < -PITCH_LIMIT) pitch <= 24'(-PITCH_LIMIT);
          else pitch <= 24'(pitch_sum);
        end
        S_CY_INIT, S_CP_INIT: begin
          cx_r  <= 33'(CORDIC_K);
          cy_r  <= '0;
          cz    <= cord_z0;
          c_neg <= cord_neg0;
          c_i   <= '0;
        end
        S_CY_RUN, S_CP_RUN: begin
          cx_r <= cx_n;
          cy_r <= cy_n;
          cz   <= cz_n;
          c_i  <= c_i + IW'(1);
          if (c_last && state == S_CY_RUN) begin
            cos_y <= c_neg ? -cx_n : cx_n;
            sin_y <= c_neg ? -cy_n : cy_n;
          end
          if (c_last && state == S_CP_RUN) begin
            cos_p <= c_neg ? -cx_n : cx_n;
            sin_p <= c_neg ? -cy_n : cy_n;
          end
        end
        S_F_ST0: vin[0] <= 28'(prod_r36);
        S_F_ST2: begin
          vin[2] <= 28'(prod_r36);
          vin[1] <= 28'((sin_p + 33'sd32) >>> 6);
          k      <= '0;
          phase  <= PH_FRONT;
        end
        S_N_ACC: begin
          sq_v   <= ((k == 2'd0) ? 56'd0 : sq_v) + prod[55:0];
          sq_r   <= '0;
          sq_bit <= 56'd1 << 54;
          k      <= (k == 2'd2) ? 2'd0 : k + 2'd1;
        end
        // one result bit per step
        S_N_SQRT: begin
          if (sq_v >= sq_r + sq_bit) begin
            sq_v <= sq_v - (sq_r + sq_bit);
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end
        S_N_DIV: begin
          // zero length falls back to the default frame
          if (nrm_len == '0) begin
            vout[0] <= '0;
            vout[1] <= '0;
            vout[2] <= '0;
            case (phase)
              PH_FRONT: vout[2] <= 28'(-ONE_Q24);
              PH_RIGHT: vout[0] <= 28'(ONE_Q24);
              default:  vout[1] <= 28'(ONE_Q24);
            endcase
          end
        end
        S_N_DIV_W: begin
          if (!div_run) begin
            vout[k] <= vin[k][27] ? -nrm_q : nrm_q;
            k       <= (k == 2'd2) ? 2'd0 : k + 2'd1;
          end
        end
        S_N_END: begin
          k <= '0;
          t <= 1'b0;
          case (phase)
            PH_FRONT: begin
              fvec[0] <= vout[0];
              fvec[1] <= vout[1];
              fvec[2] <= vout[2];
              // front cross world up
              vin[0]  <= -vout[2];
              vin[1]  <= '0;
              vin[2]  <= vout[0];
              phase   <= PH_RIGHT;
            end
            PH_RIGHT: begin
              rvec[0] <= vout[0];
              rvec[1] <= vout[1];
              rvec[2] <= vout[2];
              phase   <= PH_UP;
            end
            default: begin
              fq[0] <= to_q14(fvec[0]);
              fq[1] <= to_q14(fvec[1]);
              fq[2] <= to_q14(fvec[2]);
              rq[0] <= to_q14(rvec[0]);
              rq[1] <= to_q14(rvec[1]);
              rq[2] <= to_q14(rvec[2]);
              uq[0] <= to_q14(vout[0]);
              uq[1] <= to_q14(vout[1]);
              uq[2] <= to_q14(vout[2]);
            end
          endcase
        end
        // up = right cross front, two products per component
        S_U_ACC: begin
          t <= ~t;
          if (!t) begin
            acc <= 58'(prod);
          end else begin
            vin[k] <= 28'((up_diff + 58'sd8388608) >>> 24);
            k      <= (k == 2'd2) ? 2'd0 : k + 2'd1;
          end
        end
        S_M_SD_ST: sd <= prod[31:0];
        S_M_ADD: begin
          if (mv_n > 34'sd2147483647) pos[k] <= 32'sh7fffffff;
          else if (mv_n < -34'sd2147483648) pos[k] <= 32'sh80000000;
          else pos[k] <= 32'(mv_n);
          k <= k + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------ output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.front_x <= fq[0];
      out_data.front_y <= fq[1];
      out_data.front_z <= fq[2];
      out_data.right_x <= rq[0];
      out_data.right_y <= rq[1];
      out_data.right_z <= rq[2];
      out_data.up_x    <= uq[0];
      out_data.up_y    <= uq[1];
      out_data.up_z    <= uq[2];
      out_data.pos_x   <= pos[0];
      out_data.pos_y   <= pos[1];
      out_data.pos_z   <= pos[2];
    end
  end

endmodule
